// ===== design/assert_macros.svh =====
// assertion macros shared by the translator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequence check failed");

`endif

// ===== design/mrot_pkg.sv =====
// types, codes and link structs of the range table translator
// no dependencies; imported by mrot_cell and the core
`default_nettype none

package mrot_pkg;

  // command codes
  localparam logic [1:0] MODE_CLEAR     = 2'd0;
  localparam logic [1:0] MODE_APPEND    = 2'd1;
  localparam logic [1:0] MODE_TRANSLATE = 2'd2;
  localparam logic [1:0] MODE_IGNORE    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_SUM,
    FSM_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] range_start;
    logic [63:0] range_length;
    logic [63:0] address;
    logic [31:0] access_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  hit_index;
    logic [63:0] backing_offset;
  } out_item_t;

  // values broadcast from the core to every cell
  typedef struct packed {
    logic [63:0] range_start;
    logic [63:0] range_length;
    logic [63:0] address;
    logic [31:0] access_size;
    logic [63:0] inj_off;
    logic        kill;
  } cell_bcast_t;

  // search token handed from one cell to the next
  typedef struct packed {
    logic        valid;
    logic [63:0] off;
  } cell_link_t;

  // per-cell report back to the core
  typedef struct packed {
    logic        holding;
    logic        hit;
    logic [63:0] off;
    logic [63:0] disp;
  } cell_rsp_t;

endpackage

`default_nettype wire

// ===== design/mrot_cell.sv =====
// one range cell: holds a start/length pair and checks the search token
// depends on mrot_pkg
`default_nettype none

module mrot_cell
  import mrot_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cell_bcast_t bcast,
  input  wire logic        wr_en,
  input  wire logic        inject,
  input  wire logic        is_last,
  input  wire cell_link_t  link_i,
  output cell_link_t       link_o,
  output logic             wrap_o,
  output cell_rsp_t        rsp_o
);

  logic [63:0] start_r;
  logic [63:0] length_r;
  logic        tok_valid_r;
  logic        tok_valid_nxt;
  logic [63:0] tok_off_r;
  logic [63:0] tok_off_nxt;

  logic [63:0] size64;
  logic [63:0] disp;
  logic [63:0] room;
  logic        holds;
  logic        fwd;

  // range store, written once per append
  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_r  <= bcast.range_start;
      length_r <= bcast.range_length;
    end
  end

  // exact containment test, no wrap on either bound
  always_comb begin
    size64 = {32'd0, bcast.access_size};
    disp   = bcast.address - start_r;
    room   = length_r - size64;
    holds  = (bcast.address >= start_r) && (size64 <= length_r) && (disp <= room);
    fwd    = tok_valid_r && !holds && !bcast.kill;
  end

  // token either injected by the core or taken from the neighbour
  always_comb begin
    tok_valid_nxt = inject || (link_i.valid && !bcast.kill);
    tok_off_nxt   = inject ? bcast.inj_off : link_i.off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_off_r <= tok_off_nxt;
  end

  // pass on a missed token; the last valid cell hands it to the wrap line
  always_comb begin
    link_o.valid = fwd && !is_last;
    link_o.off   = tok_off_r + length_r;
    wrap_o       = fwd && is_last;
    rsp_o.holding = tok_valid_r;
    rsp_o.hit     = tok_valid_r && holds;
    rsp_o.off     = tok_off_r;
    rsp_o.disp    = disp;
  end

endmodule

`default_nettype wire

// ===== design/memory_range_offset_translator_core.sv =====
// top level of the range table translator: command fsm and chain of range cells
// depends on mrot_pkg, mrot_cell and assert_macros.svh
//
//  channel  ports                        handshake
//  -------  ---------------------------  ------------------------------------
//  input    start, busy, in_item         taken when start high and busy low
//  result   out_valid, out_item          one-cycle strobe, no back-pressure
//  config   cfg_valid, cfg_ready, cfg_data  written when valid and ready high
//
// clear, append, the unused mode and translate on an empty table give their
// result in the cycle after the item is taken; a new item is taken every cycle.
// a translation walks a token through the cell chain, one range per cycle:
// a hit passes the sum and emit states before its result shows, a miss
// shows its result once every range was visited; busy covers this.
// synchronous active-low reset clears the table count, hint, base and fsm.
// cfg_ready is always high; the register is meant to be written while idle.
`default_nettype none

`include "assert_macros.svh"

module memory_range_offset_translator_core
  import mrot_pkg::*;
#(
  parameter int MAX_RANGES = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [63:0] cfg_data
);

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  fsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] hint_idx_r, hint_idx_nxt;
  logic [63:0]      hint_off_r, hint_off_nxt;
  logic [CNT_W-1:0] vis_r, vis_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic [63:0]      found_off_r, found_off_nxt;
  logic [63:0]      found_disp_r, found_disp_nxt;
  logic [63:0]      base_r;
  logic [63:0]      addr_r;
  logic [31:0]      size_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             accept;
  logic             app_fire;
  logic             srch_fire;
  logic             kill;
  logic [CNT_W-1:0] last_cnt;
  logic [CNT_W-1:0] hint_ext;
  logic [CNT_W-1:0] cur_full;
  logic [IDX_W-1:0] cur_idx;
  logic [31:0]      idx_ext;

  logic [MAX_RANGES-1:0] wr_en_vec;
  logic [MAX_RANGES-1:0] inject_vec;
  logic [MAX_RANGES-1:0] last_vec;
  logic [MAX_RANGES-1:0] wrap_vec;
  logic [MAX_RANGES-1:0] tok_vec;
  cell_link_t            link_in  [MAX_RANGES];
  cell_link_t            link_out [MAX_RANGES];
  cell_rsp_t             rsp      [MAX_RANGES];
  cell_bcast_t           bcast;

  logic             any_hit;
  logic [IDX_W-1:0] hit_idx;
  logic [63:0]      hit_off;
  logic [63:0]      hit_disp;

  assign busy      = (state_r != FSM_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_data;
    end
  end

  // hold the address and size for the whole walk
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_item.address;
      size_r <= in_item.access_size;
    end
  end

  // start cell of the walk, clamped to the last valid range
  always_comb begin
    last_cnt = count_r - CNT_W'(1);
    hint_ext = CNT_W'(hint_idx_r);
    cur_full = (hint_ext > last_cnt) ? last_cnt : hint_ext;
    cur_idx  = cur_full[IDX_W-1:0];
  end

  assign app_fire  = accept && (in_item.mode == MODE_APPEND) &&
                     (count_r != CNT_W'(MAX_RANGES));
  assign srch_fire = accept && (in_item.mode == MODE_TRANSLATE) &&
                     (count_r != CNT_W'(0));

  // per-cell write, inject and last-range selects
  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      wr_en_vec[i]  = app_fire && (count_r == CNT_W'(i));
      inject_vec[i] = srch_fire && (cur_idx == IDX_W'(i));
      last_vec[i]   = (count_r == CNT_W'(i + 1));
    end
  end

  always_comb begin
    bcast.range_start  = in_item.range_start;
    bcast.range_length = in_item.range_length;
    bcast.address      = srch_fire ? in_item.address : addr_r;
    bcast.access_size  = srch_fire ? in_item.access_size : size_r;
    bcast.inj_off      = hint_off_r;
    bcast.kill         = kill;
  end

  // chain of cells; the wrap line feeds cell 0 with a zero offset
  assign link_in[0].valid = |wrap_vec;
  assign link_in[0].off   = 64'd0;

  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign link_in[g] = link_out[g-1];
    end
    mrot_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bcast   (bcast),
      .wr_en   (wr_en_vec[g]),
      .inject  (inject_vec[g]),
      .is_last (last_vec[g]),
      .link_i  (link_in[g]),
      .link_o  (link_out[g]),
      .wrap_o  (wrap_vec[g]),
      .rsp_o   (rsp[g])
    );
    assign tok_vec[g] = rsp[g].holding;
  end

  // gather the hit; at most one cell holds the token
  always_comb begin
    any_hit  = 1'b0;
    hit_idx  = '0;
    hit_off  = 64'd0;
    hit_disp = 64'd0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (rsp[i].hit) begin
        any_hit  = 1'b1;
        hit_idx  = hit_idx | IDX_W'(i);
        hit_off  = hit_off | rsp[i].off;
        hit_disp = hit_disp | rsp[i].disp;
      end
    end
  end

  assign idx_ext = 32'(found_idx_r);

  // command fsm
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    hint_idx_nxt   = hint_idx_r;
    hint_off_nxt   = hint_off_r;
    vis_nxt        = vis_r;
    found_idx_nxt  = found_idx_r;
    found_off_nxt  = found_off_r;
    found_disp_nxt = found_disp_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    kill           = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        if (start) begin
          out_item_nxt = '{status: ST_OK, hit_index: 4'd0, backing_offset: 64'd0};
          unique case (in_item.mode)
            MODE_CLEAR: begin
              count_nxt     = '0;
              hint_idx_nxt  = '0;
              hint_off_nxt  = 64'd0;
              out_valid_nxt = 1'b1;
            end
            MODE_APPEND: begin
              if (count_r == CNT_W'(MAX_RANGES)) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
              out_valid_nxt = 1'b1;
            end
            MODE_TRANSLATE: begin
              if (count_r == CNT_W'(0)) begin
                out_item_nxt.status = ST_EMPTY;
                out_valid_nxt       = 1'b1;
              end else begin
                vis_nxt   = '0;
                state_nxt = FSM_SEARCH;
              end
            end
            MODE_IGNORE: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      FSM_SEARCH: begin
        if (any_hit) begin
          found_idx_nxt  = hit_idx;
          found_off_nxt  = hit_off;
          found_disp_nxt = hit_disp;
          hint_idx_nxt   = hit_idx;
          hint_off_nxt   = hit_off;
          state_nxt      = FSM_SUM;
        end else if (vis_r == last_cnt) begin
          kill          = 1'b1;
          out_item_nxt  = '{status: ST_MISS, hit_index: 4'd0, backing_offset: 64'd0};
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
        end else begin
          vis_nxt = vis_r + CNT_W'(1);
        end
      end
      FSM_SUM: begin
        found_off_nxt = found_off_r + found_disp_r;
        state_nxt     = FSM_EMIT;
      end
      FSM_EMIT: begin
        out_item_nxt  = '{status: ST_OK, hit_index: idx_ext[3:0],
                          backing_offset: base_r + found_off_r};
        out_valid_nxt = 1'b1;
        state_nxt     = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      hint_idx_r  <= '0;
      hint_off_r  <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hint_idx_r  <= hint_idx_nxt;
      hint_off_r  <= hint_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vis_r        <= vis_nxt;
    found_idx_r  <= found_idx_nxt;
    found_off_r  <= found_off_nxt;
    found_disp_r <= found_disp_nxt;
    out_item_r   <= out_item_nxt;
  end

  // checks
  `ASSERT_ALWAYS(a_token_only_in_search, clk, rst_n, (state_r == FSM_SEARCH) || (tok_vec == '0))
  `ASSERT_ALWAYS(a_one_token_in_search, clk, rst_n, (state_r != FSM_SEARCH) || $onehot(tok_vec))
  `ASSERT_ALWAYS(a_walk_bounded, clk, rst_n, (state_r != FSM_SEARCH) || (vis_r < count_r))
  `ASSERT_NEXT(a_search_busy, clk, rst_n, srch_fire, busy && !out_valid)

endmodule

`default_nettype wire

// ===== test/tb_memory_range_offset_translator_core.sv =====
// testbench for memory_range_offset_translator_core: directed rows, then random range sessions
// depends on mrot_pkg and the core; results are checked against a range table predictor
`timescale 1ns / 1ps

module tb_memory_range_offset_translator_core
  import mrot_pkg::*;
();

  localparam int TABLE_DEPTH = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;

  // predictor state: stored ranges, search hint and backing base
  logic [63:0] tbl_start [TABLE_DEPTH];
  logic [63:0] tbl_len   [TABLE_DEPTH];
  int unsigned tbl_count = 0;
  int unsigned hint_idx  = 0;
  logic [63:0] hint_off  = '0;
  logic [63:0] base_reg  = '0;

  out_item_t   pending_outcomes [$];
  int          mismatch_count = 0;
  bit          sender_idles = 1'b1;

  typedef struct {
    in_item_t   cmd;
    bit         typed;
    logic [1:0] status;
  } dir_row_t;

  dir_row_t    dir_rows [$];

  memory_range_offset_translator_core #(
    .MAX_RANGES(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // outcome of one command on the predictor's range table
  function automatic out_item_t range_table_step(in_item_t cmd);
    out_item_t   res;
    int unsigned cur;
    logic [63:0] run_off;
    logic [64:0] acc_end;
    logic [64:0] rng_end;
    res = '0;
    case (cmd.mode)
      MODE_CLEAR: begin
        tbl_count = 0;
        hint_idx  = 0;
        hint_off  = '0;
        res.status = ST_OK;
      end
      MODE_APPEND: begin
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tbl_start[tbl_count] = cmd.range_start;
          tbl_len[tbl_count]   = cmd.range_length;
          tbl_count++;
          res.status = ST_OK;
        end
      end
      MODE_TRANSLATE: begin
        if (tbl_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          cur = (hint_idx > tbl_count - 1) ? tbl_count - 1 : hint_idx;
          run_off = hint_off;
          res.status = ST_MISS;
          // visit each range once from the hint, wrapping to range 0 with offset 0
          for (int v = 0; v < tbl_count; v++) begin
            acc_end = {1'b0, cmd.address} + {33'b0, cmd.access_size};
            rng_end = {1'b0, tbl_start[cur]} + {1'b0, tbl_len[cur]};
            if (cmd.address >= tbl_start[cur] && acc_end <= rng_end) begin
              hint_idx = cur;
              hint_off = run_off;
              res.status = ST_OK;
              res.hit_index = cur[3:0];
              res.backing_offset = base_reg + run_off + (cmd.address - tbl_start[cur]);
              return res;
            end
            run_off += tbl_len[cur];
            cur++;
            if (cur >= tbl_count) begin
              cur = 0;
              run_off = '0;
            end
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // result checker: every strobe is matched against the oldest outstanding outcome
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("result with nothing outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (out_item.status !== want.status) begin
          flag_mismatch($sformatf("status got %0d want %0d", out_item.status, want.status));
        end
        if (out_item.hit_index !== want.hit_index) begin
          flag_mismatch($sformatf("hit_index got %0d want %0d",
                                  out_item.hit_index, want.hit_index));
        end
        if (out_item.backing_offset !== want.backing_offset) begin
          flag_mismatch($sformatf("backing_offset got %h want %h",
                                  out_item.backing_offset, want.backing_offset));
        end
      end
    end
  end

  // present one item, wait for it to be taken, then record its outcome
  task automatic send_cmd(input in_item_t cmd, input bit typed, input logic [1:0] typed_status);
    out_item_t predicted;
    while (sender_idles && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
    predicted = range_table_step(cmd);
    if (typed) begin
      predicted = '0;
      predicted.status = typed_status;
    end
    pending_outcomes.push_back(predicted);
  endtask

  // hold off until every outstanding result is in and the search has settled
  task automatic drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_base(input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_reg = value;
  endtask

  function automatic void add_row(input logic [1:0] mode, input logic [63:0] rs,
                                  input logic [63:0] rl, input logic [63:0] addr,
                                  input logic [31:0] size, input bit typed,
                                  input logic [1:0] status);
    dir_row_t row;
    row.cmd.mode         = mode;
    row.cmd.range_start  = rs;
    row.cmd.range_length = rl;
    row.cmd.address      = addr;
    row.cmd.access_size  = size;
    row.typed            = typed;
    row.status           = status;
    dir_rows.push_back(row);
  endfunction

  // one session: clear, fill with ranges, then mostly translations aimed inside them
  task automatic run_session(input int n_ranges, inout int sent);
    logic [63:0] starts [$];
    logic [63:0] lens [$];
    logic [63:0] s;
    logic [63:0] l;
    logic [63:0] disp;
    logic [63:0] room;
    logic [31:0] sz;
    in_item_t    cmd;
    int          k;
    int          n_trans;
    int          pick;
    cmd = '0;
    cmd.mode = MODE_CLEAR;
    cmd.address = rand64();
    send_cmd(cmd, 1'b0, ST_OK);
    sent++;
    n_trans = $urandom_range(3, 12);
    for (int i = 0; i < n_ranges + n_trans; i++) begin
      pick = (i < n_ranges) ? 10 : $urandom_range(0, 9);
      cmd.range_start  = rand64();
      cmd.range_length = rand64();
      cmd.address      = rand64();
      cmd.access_size  = $urandom;
      if (pick == 0) begin
        // ignored command with random fields
        cmd.mode = MODE_IGNORE;
        send_cmd(cmd, 1'b0, ST_OK);
        sent++;
      end else if (pick == 1 || pick == 10) begin
        case ($urandom_range(0, 3))
          0: s = 64'($urandom_range(0, 65535));
          1: s = rand64();
          2: s = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 8191));
          default: s = (starts.size() > 0) ? starts[$] + 64'($urandom_range(0, 512)) : '0;
        endcase
        case ($urandom_range(0, 7))
          0: l = '0;
          1: l = rand64();
          2: l = '0 - s;
          3: l = ~s;
          default: l = 64'($urandom_range(1, 4096));
        endcase
        cmd.mode = MODE_APPEND;
        cmd.range_start  = s;
        cmd.range_length = l;
        send_cmd(cmd, 1'b0, ST_OK);
        sent++;
        if (starts.size() < TABLE_DEPTH) begin
          starts.push_back(s);
          lens.push_back(l);
        end
      end else if (pick < 4 || starts.size() == 0) begin
        // noise translation, often small numbers
        cmd.mode = MODE_TRANSLATE;
        if ($urandom_range(0, 1) == 0) cmd.address = 64'($urandom_range(0, 70000));
        if ($urandom_range(0, 1) == 0) cmd.access_size = $urandom_range(0, 64);
        send_cmd(cmd, 1'b0, ST_OK);
        sent++;
      end else begin
        // translation aimed inside a stored range, sometimes just past its end
        k = $urandom_range(0, starts.size() - 1);
        s = starts[k];
        l = lens[k];
        case ($urandom_range(0, 3))
          0: disp = '0;
          1: disp = l;
          default: begin
            if (l == '0) disp = '0;
            else if (l <= 64'hFFFF_FFFF) disp = 64'($urandom_range(0, l[31:0] - 1));
            else disp = rand64() % l;
          end
        endcase
        room = l - disp;
        if ($urandom_range(0, 4) == 0) begin
          sz = (room >= 64'hFFFF_FFFF) ? $urandom : room[31:0] + 32'd1;
        end else begin
          sz = (room < 64'd16) ? $urandom_range(0, room[31:0]) : $urandom_range(0, 16);
        end
        cmd.mode = MODE_TRANSLATE;
        cmd.address = s + disp;
        cmd.access_size = sz;
        send_cmd(cmd, 1'b0, ST_OK);
        sent++;
      end
    end
  endtask

  task automatic random_phase(input int quota, input bit open_full);
    int sent;
    sent = 0;
    // a session that overfills the table
    if (open_full) run_session(TABLE_DEPTH + 1, sent);
    while (sent < quota) begin
      if ($urandom_range(0, 9) == 0) run_session($urandom_range(15, 18), sent);
      else run_session($urandom_range(0, 5), sent);
    end
  endtask

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;

    // directed rows: empty table, ignored mode, boundaries, exact compare, wrap of the search
    add_row(MODE_TRANSLATE, '0, '0, '0, '0, 1'b1, ST_EMPTY);
    add_row(MODE_IGNORE, '1, '1, '1, '1, 1'b1, ST_OK);
    add_row(MODE_APPEND, 64'h1000, 64'h100, '0, '0, 1'b1, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'h1000, 32'd0, 1'b0, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'h1100, 32'd0, 1'b0, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'h10FF, 32'd2, 1'b1, ST_MISS);
    add_row(MODE_TRANSLATE, '0, '0, 64'h0FFF, 32'd1, 1'b1, ST_MISS);
    add_row(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FF00, 64'h100, '0, '0, 1'b1, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'hFFFF_FFFF_FFFF_FF00, 32'h100, 1'b0, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2, 1'b1, ST_MISS);
    add_row(MODE_APPEND, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 1'b1, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, '0, 32'hFFFF_FFFF, 1'b0, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'hFFFF_FFFF_FFFF_FFF0, 32'd16, 1'b0, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'h1080, 32'h80, 1'b0, ST_OK);
    add_row(MODE_CLEAR, '1, '1, '1, '1, 1'b1, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'h1000, 32'd0, 1'b1, ST_EMPTY);
    add_row(MODE_APPEND, 64'h5555_5555_5555_5555, '0, '0, '0, 1'b1, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'h5555_5555_5555_5555, 32'd0, 1'b0, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'h5555_5555_5555_5555, 32'd1, 1'b1, ST_MISS);
    add_row(MODE_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '0, '0, 1'b1, ST_OK);
    add_row(MODE_TRANSLATE, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, 32'd1, 1'b0, ST_OK);
    add_row(MODE_IGNORE, '0, '0, '0, '0, 1'b1, ST_OK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // base at its top value so that offsets wrap
    write_base(64'hFFFF_FFFF_FFFF_FFFF);
    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].status);

    drain();
    write_base('0);
    random_phase(150, 1'b1);

    // long stretch with the sender never idling
    drain();
    sender_idles = 1'b0;
    write_base(rand64());
    random_phase(130, 1'b0);

    drain();
    sender_idles = 1'b1;
    write_base(64'h8000_0000_0000_0000);
    random_phase(120, 1'b0);

    drain();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
